[src/step_counter_peak_valley_defines.svh]
// Assertion macros shared by the step counter. Each expects clk_i and rst_ni in scope.
`ifndef STEP_COUNTER_PEAK_VALLEY_DEFINES_SVH
`define STEP_COUNTER_PEAK_VALLEY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("step counter check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("step counter check failed");

`endif

[src/spv_pkg.sv]
package spv_pkg;

  localparam int unsigned WindowLen = 5;
  localparam int unsigned IdxW      = $clog2(WindowLen);
  localparam int unsigned FillW     = $clog2(WindowLen + 1);
  localparam int unsigned SumW      = 16 + $clog2(WindowLen);

  localparam logic [15:0] QOne    = 16'd256;
  localparam logic [15:0] Lvl43   = 16'd1101;
  localparam logic [15:0] Lvl33   = 16'd845;
  localparam logic [15:0] Lvl23   = 16'd589;
  localparam logic [15:0] Lvl20   = 16'd512;
  localparam logic [15:0] Lvl17   = 16'd435;

  localparam logic [SumW-1:0] SumThr8 = SumW'(8 * QOne * WindowLen);
  localparam logic [SumW-1:0] SumThr7 = SumW'(7 * QOne * WindowLen);
  localparam logic [SumW-1:0] SumThr4 = SumW'(4 * QOne * WindowLen);
  localparam logic [SumW-1:0] SumThr3 = SumW'(3 * QOne * WindowLen);

  localparam logic [7:0] RiseMax = 8'd255;
  localparam logic [7:0] RiseMin = 8'd2;

  typedef enum logic [2:0] {
    CfgPeakMin    = 3'd0,
    CfgPeakMax    = 3'd1,
    CfgSwingFloor = 3'd2,
    CfgMinGap     = 3'd3,
    CfgMaxGap     = 3'd4,
    CfgDashGap    = 3'd5,
    CfgRunGap     = 3'd6
  } cfg_idx_e;

  localparam logic [15:0] RstPeakMin    = 16'd2816;
  localparam logic [15:0] RstPeakMax    = 16'd5018;
  localparam logic [15:0] RstSwingFloor = 16'd435;
  localparam logic [15:0] RstMinGap     = 16'd150;
  localparam logic [15:0] RstMaxGap     = 16'd2000;
  localparam logic [15:0] RstDashGap    = 16'd250;
  localparam logic [15:0] RstRunGap     = 16'd400;

  typedef struct packed {
    logic [15:0] peak_min;
    logic [15:0] peak_max;
    logic [15:0] swing_floor;
    logic [15:0] min_gap_ms;
    logic [15:0] max_gap_ms;
    logic [15:0] dash_gap_ms;
    logic [15:0] run_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic        peak;
    logic        pos;
    logic [15:0] swing;
  } peak_evt_t;

endpackage

[src/spv_cfg_regs.sv]
module spv_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [15:0]   cfg_wdata_i,
  output spv_pkg::cfg_t cfg_o
);

  spv_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_min    <= spv_pkg::RstPeakMin;
      cfg_q.peak_max    <= spv_pkg::RstPeakMax;
      cfg_q.swing_floor <= spv_pkg::RstSwingFloor;
      cfg_q.min_gap_ms  <= spv_pkg::RstMinGap;
      cfg_q.max_gap_ms  <= spv_pkg::RstMaxGap;
      cfg_q.dash_gap_ms <= spv_pkg::RstDashGap;
      cfg_q.run_gap_ms  <= spv_pkg::RstRunGap;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spv_pkg::CfgPeakMin:    cfg_q.peak_min    <= cfg_wdata_i;
        spv_pkg::CfgPeakMax:    cfg_q.peak_max    <= cfg_wdata_i;
        spv_pkg::CfgSwingFloor: cfg_q.swing_floor <= cfg_wdata_i;
        spv_pkg::CfgMinGap:     cfg_q.min_gap_ms  <= cfg_wdata_i;
        spv_pkg::CfgMaxGap:     cfg_q.max_gap_ms  <= cfg_wdata_i;
        spv_pkg::CfgDashGap:    cfg_q.dash_gap_ms <= cfg_wdata_i;
        spv_pkg::CfgRunGap:     cfg_q.run_gap_ms  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/spv_peak_detect.sv]
module spv_peak_detect (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [15:0]        sample_i,
  input  spv_pkg::cfg_t      cfg_i,
  output spv_pkg::peak_evt_t evt_o
);

  logic [15:0] prev_q, valley_q, valley_d;
  logic        rising_q, rising_d;
  logic [7:0]  rise_run_q, rise_run_d;
  logic        active, cur_gt;

  // Detection is suspended, with its state held, whenever the previous sample was zero.
  assign active = (prev_q != 16'd0);
  assign cur_gt = (sample_i > prev_q);

  always_comb begin
    rising_d   = rising_q;
    rise_run_d = rise_run_q;
    valley_d   = valley_q;
    if (active) begin
      rising_d = cur_gt;
      if (cur_gt) begin
        if (rise_run_q != spv_pkg::RiseMax) begin
          rise_run_d = rise_run_q + 8'd1;
        end
        if (!rising_q) begin
          valley_d = prev_q;
        end
      end else begin
        rise_run_d = 8'd0;
      end
    end
  end

  assign evt_o.peak  = active && !cur_gt && rising_q && (rise_run_q >= spv_pkg::RiseMin) &&
                       (prev_q >= cfg_i.peak_min) && (prev_q <= cfg_i.peak_max);
  assign evt_o.pos   = (prev_q >= valley_q);
  assign evt_o.swing = prev_q - valley_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= 16'd0;
      valley_q   <= 16'd0;
      rising_q   <= 1'b0;
      rise_run_q <= 8'd0;
    end else if (fire_i) begin
      prev_q     <= sample_i;
      valley_q   <= valley_d;
      rising_q   <= rising_d;
      rise_run_q <= rise_run_d;
    end
  end

endmodule

[src/spv_swing_window.sv]
module spv_swing_window (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [15:0] swing_i,
  output logic [15:0] thr_o
);

  logic [15:0]                  win_q [spv_pkg::WindowLen];
  logic [spv_pkg::FillW-1:0]    fill_q;
  logic [15:0]                  thr_q;
  logic [spv_pkg::SumW-1:0]     sum;
  logic [15:0]                  level;
  logic                         full;

  always_comb begin
    sum = '0;
    for (int i = 0; i < spv_pkg::WindowLen; i++) begin
      sum = sum + spv_pkg::SumW'(win_q[i]);
    end
  end

  always_comb begin
    if (sum >= spv_pkg::SumThr8) begin
      level = spv_pkg::Lvl43;
    end else if (sum >= spv_pkg::SumThr7) begin
      level = spv_pkg::Lvl33;
    end else if (sum >= spv_pkg::SumThr4) begin
      level = spv_pkg::Lvl23;
    end else if (sum >= spv_pkg::SumThr3) begin
      level = spv_pkg::Lvl20;
    end else begin
      level = spv_pkg::Lvl17;
    end
  end

  assign full = (fill_q >= spv_pkg::FillW'(spv_pkg::WindowLen));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < spv_pkg::WindowLen; i++) begin
        win_q[i] <= 16'd0;
      end
      fill_q <= '0;
      thr_q  <= spv_pkg::Lvl20;
    end else if (push_i) begin
      if (!full) begin
        win_q[fill_q[spv_pkg::IdxW-1:0]] <= swing_i;
        fill_q <= fill_q + spv_pkg::FillW'(1);
      end else begin
        // The level is taken from the window before the new swing enters.
        thr_q <= level;
        for (int i = 1; i < spv_pkg::WindowLen; i++) begin
          win_q[i-1] <= win_q[i];
        end
        win_q[spv_pkg::WindowLen-1] <= swing_i;
      end
    end
  end

  assign thr_o = thr_q;

endmodule

[src/spv_step_count.sv]
module spv_step_count (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [31:0]        timestamp_i,
  input  spv_pkg::peak_evt_t evt_i,
  input  logic [15:0]        thr_i,
  input  spv_pkg::cfg_t      cfg_i,
  output logic               push_o,
  output logic [31:0]        step_total_o,
  output logic [31:0]        run_total_o,
  output logic [31:0]        dash_total_o,
  output logic               step_seen_o
);

  logic [31:0] latest_q, steps_q, runs_q, dashes_q;
  logic        seen_q;
  logic [31:0] gap;
  logic        gap_ok, step;

  // Gaps are differences modulo 2^32, so a wrapped timestamp still works.
  assign gap    = timestamp_i - latest_q;
  assign gap_ok = (gap >= {16'd0, cfg_i.min_gap_ms});
  assign step   = evt_i.peak && gap_ok && (gap <= {16'd0, cfg_i.max_gap_ms}) &&
                  evt_i.pos && (evt_i.swing >= thr_i);
  assign push_o = fire_i && evt_i.peak && gap_ok && evt_i.pos &&
                  (evt_i.swing >= cfg_i.swing_floor);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q <= 32'd0;
      steps_q  <= 32'd0;
      runs_q   <= 32'd0;
      dashes_q <= 32'd0;
      seen_q   <= 1'b0;
    end else if (fire_i) begin
      seen_q <= step;
      if (step || push_o) begin
        latest_q <= timestamp_i;
      end
      if (step) begin
        steps_q <= steps_q + 32'd1;
        if (gap < {16'd0, cfg_i.dash_gap_ms}) begin
          dashes_q <= dashes_q + 32'd1;
        end else if (gap < {16'd0, cfg_i.run_gap_ms}) begin
          runs_q <= runs_q + 32'd1;
        end
      end
    end
  end

  assign step_total_o = steps_q;
  assign run_total_o  = runs_q;
  assign dash_total_o = dashes_q;
  assign step_seen_o  = seen_q;

endmodule

[src/step_counter_peak_valley.sv]
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_ready_o  accel_magnitude_i, timestamp_ms_i
// out       output     out_valid_o / out_ready_i step_total_o, run_total_o,
//                                               dash_total_o, step_seen_o
// cfg       input      cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// An item waits in the input register while the result is stalled, then passes to
// the result registers. One item is taken per cycle while no stall holds the flow.
// The rate is set by the single pass from the input register through the detector,
// the five-entry window sum and the counters. Reset is asynchronous and restores
// every register at once but mag_q and ts_q, which have no reset. A stalled result
// holds the input register, which still takes one more item.
`include "step_counter_peak_valley_defines.svh"

module step_counter_peak_valley (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] accel_magnitude_i,
  input  logic [31:0] timestamp_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] step_total_o,
  output logic [31:0] run_total_o,
  output logic [31:0] dash_total_o,
  output logic        step_seen_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  logic               in_valid_q, out_valid_q;
  logic [15:0]        mag_q;
  logic [31:0]        ts_q;
  logic               advance, fire, push;
  logic [15:0]        thr;
  spv_pkg::cfg_t      cfg;
  spv_pkg::peak_evt_t evt;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mag_q <= accel_magnitude_i;
      ts_q  <= timestamp_ms_i;
    end
  end

  spv_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  spv_peak_detect u_detect (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .sample_i (mag_q),
    .cfg_i    (cfg),
    .evt_o    (evt)
  );

  spv_swing_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .swing_i (evt.swing),
    .thr_o   (thr)
  );

  spv_step_count u_count (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .timestamp_i  (ts_q),
    .evt_i        (evt),
    .thr_i        (thr),
    .cfg_i        (cfg),
    .push_o       (push),
    .step_total_o (step_total_o),
    .run_total_o  (run_total_o),
    .dash_total_o (dash_total_o),
    .step_seen_o  (step_seen_o)
  );

  assign out_valid_o = out_valid_q;

  `SPV_ASSERT_NEXT(a_step_total_tracks_seen, fire,
                   step_total_o == $past(step_total_o) + {31'd0, step_seen_o})
  `SPV_ASSERT_NEXT(a_run_dash_need_step, fire,
                   step_seen_o || ((run_total_o == $past(run_total_o)) &&
                   (dash_total_o == $past(dash_total_o))))
  `SPV_ASSERT_SAME(a_window_push_on_fire, push, fire && evt.peak)
  `SPV_ASSERT_SAME(a_stall_blocks_input, in_valid_q && !advance, !in_ready_o)

endmodule

[bench/step_counter_peak_valley_test.sv]
module step_counter_peak_valley_test;

  localparam logic [2:0] CfgUnused = 3'd7;

  typedef struct {
    logic [15:0] mag;
    logic [31:0] ms;
  } sample_t;

  typedef struct {
    logic [31:0] steps;
    logic [31:0] runs;
    logic [31:0] dashes;
    logic        seen;
  } tally_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] accel_mag = '0;
  logic [31:0] stamp_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] step_total;
  logic [31:0] run_total;
  logic [31:0] dash_total;
  logic        step_seen;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  step_counter_peak_valley dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .accel_magnitude_i (accel_mag),
    .timestamp_ms_i    (stamp_ms),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .step_total_o      (step_total),
    .run_total_o       (run_total),
    .dash_total_o      (dash_total),
    .step_seen_o       (step_seen),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_wdata_i       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_t     pending_samples[$];
  tally_t      tallies_due[$];
  int unsigned mismatches = 0;
  int unsigned samples_taken = 0;
  bit          steady = 1'b0;
  logic        sink_hold = 1'b0;
  logic [31:0] wave_ms = '0;
  int unsigned wave_mag = 1000;

  // Private copy of the detector state and the register settings.
  spv_pkg::cfg_t live_cfg = '{spv_pkg::RstPeakMin, spv_pkg::RstPeakMax,
                              spv_pkg::RstSwingFloor, spv_pkg::RstMinGap,
                              spv_pkg::RstMaxGap, spv_pkg::RstDashGap,
                              spv_pkg::RstRunGap};
  logic [15:0] last_mag = '0;
  logic        climbing = 1'b0;
  logic [7:0]  climb_len = '0;
  logic [7:0]  climb_len_prev = '0;
  logic [15:0] peak_mag = '0;
  logic [15:0] valley_mag = '0;
  logic [31:0] prev_peak_ms = '0;
  logic [31:0] last_peak_ms = '0;
  logic [15:0] thresh = spv_pkg::Lvl20;
  logic [15:0] swing_hist [spv_pkg::WindowLen] = '{default: '0};
  int unsigned swings_held = 0;
  logic [31:0] step_cnt = '0;
  logic [31:0] run_cnt = '0;
  logic [31:0] dash_cnt = '0;

  function automatic tally_t tally_sample(input logic [15:0] mag, input logic [31:0] now);
    tally_t      r;
    logic        was_climbing;
    logic        at_peak;
    logic        upward;
    logic [15:0] swing;
    logic [31:0] gap;
    int unsigned sum;
    int unsigned k;
    r.seen = 1'b0;
    if (last_mag != '0) begin
      was_climbing = climbing;
      if (mag > last_mag) begin
        climbing = 1'b1;
        if (climb_len != 8'd255) climb_len++;
      end else begin
        climb_len_prev = climb_len;
        climb_len = '0;
        climbing = 1'b0;
      end
      at_peak = !climbing && was_climbing && climb_len_prev >= 8'd2 &&
                last_mag >= live_cfg.peak_min && last_mag <= live_cfg.peak_max;
      if (at_peak) begin
        peak_mag = last_mag;
      end else if (!was_climbing && climbing) begin
        valley_mag = last_mag;
      end
      if (at_peak) begin
        upward = peak_mag >= valley_mag;
        swing = upward ? peak_mag - valley_mag : '0;
        prev_peak_ms = last_peak_ms;
        gap = now - prev_peak_ms;
        if (gap >= live_cfg.min_gap_ms && gap <= live_cfg.max_gap_ms && upward &&
            swing >= thresh) begin
          last_peak_ms = now;
          step_cnt++;
          r.seen = 1'b1;
          if (gap < live_cfg.dash_gap_ms) begin
            dash_cnt++;
          end else if (gap < live_cfg.run_gap_ms) begin
            run_cnt++;
          end
        end
        if (gap >= live_cfg.min_gap_ms && upward && swing >= live_cfg.swing_floor) begin
          last_peak_ms = now;
          if (swings_held < spv_pkg::WindowLen) begin
            swing_hist[swings_held] = swing;
            swings_held++;
          end else begin
            // The new level comes from the window as it stood before this swing.
            sum = 0;
            for (k = 0; k < spv_pkg::WindowLen; k++) sum += swing_hist[k];
            if (sum >= 8 * 256 * spv_pkg::WindowLen) thresh = spv_pkg::Lvl43;
            else if (sum >= 7 * 256 * spv_pkg::WindowLen) thresh = spv_pkg::Lvl33;
            else if (sum >= 4 * 256 * spv_pkg::WindowLen) thresh = spv_pkg::Lvl23;
            else if (sum >= 3 * 256 * spv_pkg::WindowLen) thresh = spv_pkg::Lvl20;
            else thresh = spv_pkg::Lvl17;
            for (k = 1; k < spv_pkg::WindowLen; k++) swing_hist[k - 1] = swing_hist[k];
            swing_hist[spv_pkg::WindowLen - 1] = swing;
          end
        end
      end
    end
    last_mag = mag;
    r.steps = step_cnt;
    r.runs = run_cnt;
    r.dashes = dash_cnt;
    return r;
  endfunction

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk or negedge rst_n) begin : drive_samples
    sample_t     item;
    int unsigned send_pause;
    if (!rst_n) begin
      in_valid <= 1'b0;
      accel_mag <= '0;
      stamp_ms <= '0;
      send_pause = 0;
    end else begin
      if (in_valid && in_ready) begin
        tallies_due.push_back(tally_sample(accel_mag, stamp_ms));
        samples_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_pause != 0) begin
          send_pause--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          item = pending_samples.pop_front();
          in_valid <= 1'b1;
          accel_mag <= item.mag;
          stamp_ms <= item.ms;
          send_pause = pick_pause();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin : check_tallies
    tally_t      want;
    int unsigned recv_pause;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_pause = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (tallies_due.size() == 0) begin
          report_mismatch("result arrived with no sample outstanding");
        end else begin
          want = tallies_due.pop_front();
          if (step_total !== want.steps)
            report_mismatch($sformatf("step_total %0d, expected %0d", step_total, want.steps));
          if (run_total !== want.runs)
            report_mismatch($sformatf("run_total %0d, expected %0d", run_total, want.runs));
          if (dash_total !== want.dashes)
            report_mismatch($sformatf("dash_total %0d, expected %0d", dash_total, want.dashes));
          if (step_seen !== want.seen)
            report_mismatch($sformatf("step_seen %0b, expected %0b", step_seen, want.seen));
        end
        recv_pause = pick_pause();
      end
      if (recv_pause != 0) begin
        recv_pause--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !sink_hold;
      end
    end
  end

  // Two long hold-offs on the result side while samples keep coming.
  always @(posedge clk or negedge rst_n) begin : hold_results
    int unsigned hold_left;
    int unsigned holds_done;
    if (!rst_n) begin
      sink_hold <= 1'b0;
      hold_left = 0;
      holds_done = 0;
    end else if (hold_left != 0) begin
      hold_left--;
      if (hold_left == 0) sink_hold <= 1'b0;
    end else if (holds_done < 2 && samples_taken >= 300 * (holds_done + 1)) begin
      hold_left = 400;
      holds_done++;
      sink_hold <= 1'b1;
    end
  end

  task automatic add_sample(input logic [15:0] mag, input logic [31:0] ms);
    wave_ms = ms;
    pending_samples.push_back('{mag, ms});
  endtask

  function automatic logic [31:0] next_dt();
    if ($urandom_range(0, 39) == 0) return $urandom_range(1500, 4000);
    return $urandom_range(15, 90);
  endfunction

  task automatic add_noise();
    case ($urandom_range(0, 3))
      0: add_sample('0, wave_ms + $urandom_range(1, 100));
      1: add_sample(16'($urandom_range(0, 65535)), $urandom());
      default: add_sample(16'($urandom_range(0, 65535)), wave_ms + $urandom_range(0, 200));
    endcase
  endtask

  // One stride: a strict rise to a peak, then a fall to the next valley.
  task automatic add_stride(input int unsigned lo, input int unsigned hi);
    int unsigned peak;
    int unsigned valley;
    int unsigned up_n;
    int unsigned down_n;
    int unsigned k;
    peak = $urandom_range(2600, 5300);
    if (peak < wave_mag + 200) peak = wave_mag + 200;
    valley = peak - $urandom_range(lo, hi);
    up_n = $urandom_range(2, 6);
    down_n = $urandom_range(1, 5);
    for (k = 1; k <= up_n; k++)
      add_sample(16'(wave_mag + (peak - wave_mag) * k / up_n), wave_ms + next_dt());
    for (k = 1; k <= down_n; k++)
      add_sample(16'(peak - (peak - valley) * k / down_n), wave_ms + next_dt());
    wave_mag = valley;
  endtask

  // Bursts of strides whose swing band sets where the threshold settles.
  task automatic add_walk(input int unsigned n);
    int unsigned lo;
    int unsigned hi;
    int unsigned burst;
    int unsigned j;
    while (pending_samples.size() < n) begin
      case ($urandom_range(0, 4))
        0: begin lo = 150; hi = 700; end
        1: begin lo = 700; hi = 1000; end
        2: begin lo = 1000; hi = 1700; end
        3: begin lo = 1750; hi = 1950; end
        default: begin lo = 2000; hi = 2550; end
      endcase
      burst = $urandom_range(4, 16);
      for (j = 0; j < burst && pending_samples.size() < n; j++) begin
        if ($urandom_range(0, 9) == 0) add_noise();
        add_stride(lo, hi);
      end
    end
  endtask

  task automatic settle_block();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || tallies_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      spv_pkg::CfgPeakMin:    live_cfg.peak_min = val;
      spv_pkg::CfgPeakMax:    live_cfg.peak_max = val;
      spv_pkg::CfgSwingFloor: live_cfg.swing_floor = val;
      spv_pkg::CfgMinGap:     live_cfg.min_gap_ms = val;
      spv_pkg::CfgMaxGap:     live_cfg.max_gap_ms = val;
      spv_pkg::CfgDashGap:    live_cfg.dash_gap_ms = val;
      spv_pkg::CfgRunGap:     live_cfg.run_gap_ms = val;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input spv_pkg::cfg_t s);
    write_reg(spv_pkg::CfgPeakMin, s.peak_min);
    write_reg(spv_pkg::CfgPeakMax, s.peak_max);
    write_reg(spv_pkg::CfgSwingFloor, s.swing_floor);
    write_reg(spv_pkg::CfgMinGap, s.min_gap_ms);
    write_reg(spv_pkg::CfgMaxGap, s.max_gap_ms);
    write_reg(spv_pkg::CfgDashGap, s.dash_gap_ms);
    write_reg(spv_pkg::CfgRunGap, s.run_gap_ms);
  endtask

  initial begin : run_phases
    int unsigned   k;
    spv_pkg::cfg_t s;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Zero restarts, full-scale samples, a dash, a run, a walk, a peak that comes
    // too soon, and a peak at the upper limit across the timestamp wrap.
    add_sample(16'd0, 32'd0);
    add_sample(16'd65535, 32'd5);
    add_sample(16'd0, 32'd10);
    add_sample(16'd1000, 32'd20);
    add_sample(16'd2000, 32'd40);
    add_sample(16'd3000, 32'd60);
    add_sample(16'd4000, 32'd200);
    add_sample(16'd3500, 32'd220);
    add_sample(16'd2000, 32'd240);
    add_sample(16'd1500, 32'd260);
    add_sample(16'd2500, 32'd280);
    add_sample(16'd3500, 32'd300);
    add_sample(16'd4500, 32'd320);
    add_sample(16'd4000, 32'd470);
    add_sample(16'd1000, 32'd490);
    add_sample(16'd2000, 32'd510);
    add_sample(16'd3000, 32'd530);
    add_sample(16'd3500, 32'd560);
    add_sample(16'd3000, 32'd1000);
    add_sample(16'd1000, 32'd1020);
    add_sample(16'd2000, 32'd1040);
    add_sample(16'd3000, 32'd1060);
    add_sample(16'd2900, 32'd1100);
    add_sample(16'd4000, 32'hFFFF_FF00);
    add_sample(spv_pkg::RstPeakMax, 32'hFFFF_FFF0);
    add_sample(16'd0, 32'h0000_0100);
    settle_block();

    add_walk(200);
    settle_block();

    s = '{peak_min: 16'd0, peak_max: 16'hFFFF, swing_floor: 16'd0, min_gap_ms: 16'd0,
          max_gap_ms: 16'hFFFF, dash_gap_ms: 16'd0, run_gap_ms: 16'hFFFF};
    apply_cfg(s);
    // A rise long enough to saturate the rise counter.
    add_sample(16'd900, wave_ms + 10);
    for (k = 0; k < 262; k++) add_sample(16'(1000 + 150 * k), wave_ms + 2);
    add_sample(16'd2000, wave_ms + 20);
    wave_mag = 2000;
    add_walk(370);
    settle_block();

    steady = 1'b1;
    s = '{peak_min: 16'hFFFF, peak_max: 16'hFFFF, swing_floor: 16'hFFFF, min_gap_ms: 16'd0,
          max_gap_ms: 16'd0, dash_gap_ms: 16'hFFFF, run_gap_ms: 16'd0};
    apply_cfg(s);
    write_reg(CfgUnused, 16'h5A5A);
    add_walk(60);
    settle_block();

    steady = 1'b0;
    s.peak_min = 16'($urandom_range(1500, 3000));
    s.peak_max = 16'($urandom_range(4000, 6000));
    s.swing_floor = 16'($urandom_range(0, 1000));
    s.min_gap_ms = 16'($urandom_range(0, 300));
    s.max_gap_ms = 16'($urandom_range(800, 3000));
    s.dash_gap_ms = 16'($urandom_range(100, 500));
    s.run_gap_ms = 16'($urandom_range(200, 800));
    apply_cfg(s);
    wave_ms = 32'hFFFF_F000;
    add_walk(150);
    settle_block();

    s = '{spv_pkg::RstPeakMin, spv_pkg::RstPeakMax, spv_pkg::RstSwingFloor,
          spv_pkg::RstMinGap, spv_pkg::RstMaxGap, spv_pkg::RstDashGap,
          spv_pkg::RstRunGap};
    apply_cfg(s);
    add_walk(150);
    settle_block();

    if (mismatches == 0 && tallies_due.size() == 0) begin
      $display("** step_counter_peak_valley: PASSED **");
    end else begin
      $display("** step_counter_peak_valley: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("** step_counter_peak_valley: FAILED **");
    $finish;
  end

endmodule
